// ----- rtl/core/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 package
// S-box, GF(2^8) helpers and round functions shared by the encryption core.
// ----------------------------------------------------------------------------
package aes_pkg;

	localparam int Rounds   = 10;
	localparam int HalfW    = 64;
	localparam int BlockW   = 128;
	localparam int CfgIdxW  = 1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} cfg_reg_t;

	typedef logic [BlockW-1:0] block_t;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] r;
		unique case (x)
			8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
			8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
			8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
			8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
			8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
			8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
			8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
			8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
			8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
			8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
			8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
			8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
			8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
			8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
			8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
			8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
			8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
			8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
			8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
			8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
			8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
			8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
			8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
			8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
			8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
			8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
			8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
			8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
			8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
			8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
			8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
			8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
			8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
			8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
			8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
			8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
			8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
			8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
			8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
			8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
			8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
			8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
			8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
			8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
			8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
			8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
			8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
			8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
			8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
			8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
			8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
			8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
			8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
			8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
			8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
			8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
			8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
			8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
			8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
			8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
			8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
			8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
			8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
			8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; 8'hFF: r=8'h16;
			default: r=8'h00;
		endcase
		return r;
	endfunction

	// multiply by x in GF(2^8), polynomial 0x11B
	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
	endfunction

	// byte n of a block; byte 0 in the top bits
	function automatic logic [7:0] byte_of(input block_t b, input int n);
		return b[BlockW-1-8*n -: 8];
	endfunction

	// round constant for round r (0-based)
	function automatic logic [7:0] rcon(input int r);
		logic [7:0] c;
		c = 8'h01;
		for (int i = 0; i < r; i++) c = xtime(c);
		return c;
	endfunction

	// next round key
	function automatic block_t key_step(input block_t k, input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
		t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// SubBytes + ShiftRows, then MixColumns unless last
	function automatic block_t round_fn(input block_t s, input logic last);
		block_t t, m;
		logic [7:0] a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[BlockW-1-8*(4*c+r) -: 8] = sbox(byte_of(s, 4*((c+r)%4)+r));
		for (int c = 0; c < 4; c++) begin
			a0 = byte_of(t, 4*c);   a1 = byte_of(t, 4*c+1);
			a2 = byte_of(t, 4*c+2); a3 = byte_of(t, 4*c+3);
			al = a0 ^ a1 ^ a2 ^ a3;
			m[BlockW-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			m[BlockW-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			m[BlockW-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			m[BlockW-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return last ? t : m;
	endfunction

endpackage

// ----- rtl/core/aes128_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Round-unrolled pipeline, one round per stage, keys expanded alongside.
// ----------------------------------------------------------------------------
//  channel | signals                               | transfer when
//  --------+---------------------------------------+---------------------
//  input   | valid_in, stall_in, plain_high/low    | valid_in & !stall_in
//  output  | valid_out, stall_out, cipher_high/low | valid_out & !stall_out
//  config  | cfg_valid, cfg_ready, cfg_index/data  | cfg_valid & cfg_ready
//
//  Stage 0 does the initial key XOR, stages 1..10 one round each, the last
//  stage is the output register. One block per cycle unless stalled.
//  Round keys travel with the data, so each block keeps its own key schedule.
//  A stall from the output holds every occupied stage; empty stages still fill
//  (stall_in only rises when the pipe is full and the output is stalled).
//  Reset clears the valid bits and both key registers.
// ----------------------------------------------------------------------------
module aes128_block_encrypt
	import aes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	output logic              stall_in,
	input  logic [HalfW-1:0]  plain_high,
	input  logic [HalfW-1:0]  plain_low,
	output logic              valid_out,
	input  logic              stall_out,
	output logic [HalfW-1:0]  cipher_high,
	output logic [HalfW-1:0]  cipher_low,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CfgIdxW:0]  cfg_index,
	input  logic [HalfW-1:0]  cfg_data
);

	logic [HalfW-1:0] key_high_q, key_low_q;

	// stage k holds the state after k rounds and round key k
	// (the last round key is only folded into the state, never stored)
	block_t             st_s [Rounds+1];
	block_t             rk_s [Rounds];
	logic [Rounds:0]    vld_s;
	logic [Rounds+1:0]  adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid && cfg_ready && cfg_index[CfgIdxW] == 1'b0) begin
			unique case (cfg_reg_t'(cfg_index[CfgIdxW-1:0]))
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default:      key_low_q  <= key_low_q;
			endcase
		end
	end

	// stage k may load when it is empty or the stage after it moves on
	always_comb begin
		adv[Rounds+1] = !stall_out;
		for (int k = Rounds; k >= 0; k--)
			adv[k] = !vld_s[k] || adv[k+1];
	end
	assign stall_in = !adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= valid_in;
			for (int k = 1; k <= Rounds; k++)
				if (adv[k]) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			st_s[0] <= {plain_high, plain_low} ^ {key_high_q, key_low_q};
			rk_s[0] <= {key_high_q, key_low_q};
		end
		for (int k = 1; k < Rounds; k++) begin
			if (adv[k]) rk_s[k] <= key_step(rk_s[k-1], rcon(k-1));
		end
		for (int k = 1; k <= Rounds; k++) begin
			if (adv[k]) begin
				st_s[k] <= round_fn(st_s[k-1], k == Rounds)
				           ^ key_step(rk_s[k-1], rcon(k-1));
			end
		end
	end

	assign valid_out   = vld_s[Rounds];
	assign cipher_high = st_s[Rounds][BlockW-1:HalfW];
	assign cipher_low  = st_s[Rounds][HalfW-1:0];

endmodule

// ----- rtl/core/aes_checker.sv -----
// ----------------------------------------------------------------------------
// AES-128 port checker
// Watches the top-level ports and flags handshake and config slips.
// ----------------------------------------------------------------------------
module aes_checker
	import aes_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              valid_in,
	input logic              stall_in,
	input logic              valid_out,
	input logic              stall_out,
	input logic [HalfW-1:0]  cipher_high,
	input logic              cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_out && stall_out |=> valid_out && $stable(cipher_high))
		else $error("output dropped while stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_in && stall_in |=> valid_in)
		else $error("input offer withdrawn while stalled");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!stall_out |-> !stall_in)
		else $error("input stalled while output drains");

	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		stall_in |-> valid_out)
		else $error("input stalled with empty output");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
	.clk(clk), .arst_n(arst_n), .valid_in(valid_in), .stall_in(stall_in),
	.valid_out(valid_out), .stall_out(stall_out), .cipher_high(cipher_high),
	.cfg_ready(cfg_ready)
);

// ----- bench/aes128_cipher_checker.sv -----
// ----------------------------------------------------------------------------
// AES-128 cipher checker
// Watches the config, plaintext and ciphertext channels, predicts each
// ciphertext and compares it, in order, with what the block returns.
// ----------------------------------------------------------------------------
module aes128_cipher_checker
	import aes_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  logic              stall_in,
	input  logic [HalfW-1:0]  plain_high,
	input  logic [HalfW-1:0]  plain_low,
	input  logic              valid_out,
	input  logic              stall_out,
	input  logic [HalfW-1:0]  cipher_high,
	input  logic [HalfW-1:0]  cipher_low,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CfgIdxW:0]  cfg_index,
	input  logic [HalfW-1:0]  cfg_data,
	output int                errors,
	output int                pending,
	output int                blocks_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [7:0] sub_lut [256];
	logic [HalfW-1:0] key_hi_m, key_lo_m;
	logic [BlockW-1:0] cipher_q [$];

	initial begin
		logic [7:0] p, q, x;
		// build the S-box from the field inverse and the affine map
		p = 8'h01; q = 8'h01;
		sub_lut[0] = 8'h63;
		do begin
			p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1B : 8'h00);
			q = q ^ {q[6:0], 1'b0};
			q = q ^ {q[5:0], 2'b0};
			q = q ^ {q[3:0], 4'b0};
			if (q[7]) q = q ^ 8'h09;
			x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
				^ {q[3:0], q[7:4]};
			sub_lut[p] = x ^ 8'h63;
		end while (p != 8'h01);
	end

	function automatic logic [7:0] dbl(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
	endfunction

	function automatic logic [BlockW-1:0] encrypt_block(input logic [BlockW-1:0] pt,
			input logic [BlockW-1:0] key);
		logic [7:0] st [16], rk [16], t [16], t0, t1, t2, t3, a0, a1, a2, a3, al, rc;
		logic [BlockW-1:0] res;
		rc = 8'h01;
		for (int n = 0; n < 16; n++) begin
			st[n] = pt[127-8*n -: 8] ^ key[127-8*n -: 8];
			rk[n] = key[127-8*n -: 8];
		end
		for (int rnd = 0; rnd < 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[4*c+r] = sub_lut[st[4*((c+r)%4)+r]];
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				al = a0 ^ a1 ^ a2 ^ a3;
				if (rnd != 9) begin
					t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
					t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
					t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
					t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
				end
			end
			t0 = sub_lut[rk[13]] ^ rc; t1 = sub_lut[rk[14]];
			t2 = sub_lut[rk[15]]; t3 = sub_lut[rk[12]];
			rk[0] ^= t0; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
			for (int n = 4; n < 16; n++) rk[n] ^= rk[n-4];
			rc = dbl(rc);
			for (int n = 0; n < 16; n++) st[n] = t[n] ^ rk[n];
		end
		for (int n = 0; n < 16; n++) res[127-8*n -: 8] = st[n];
		return res;
	endfunction

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [BlockW-1:0] exp_ct;
		if (!arst_n) begin
			key_hi_m = '0;
			key_lo_m = '0;
			errors = 0;
			blocks_seen = 0;
			cipher_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == {1'b0, REG_KEY_HIGH}) key_hi_m = cfg_data;
				else if (cfg_index == {1'b0, REG_KEY_LOW}) key_lo_m = cfg_data;
			end
			if (valid_in && !stall_in)
				cipher_q.push_back(encrypt_block({plain_high, plain_low},
					{key_hi_m, key_lo_m}));
			if (valid_out && !stall_out) begin
				blocks_seen++;
				if (cipher_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected ciphertext %h_%h", $time,
						cipher_high, cipher_low);
				end else begin
					exp_ct = cipher_q.pop_front();
					if (cipher_high !== exp_ct[127:64]) begin
						errors++;
						$display("%0t: cipher_high expected %h got %h", $time,
							exp_ct[127:64], cipher_high);
					end
					if (cipher_low !== exp_ct[63:0]) begin
						errors++;
						$display("%0t: cipher_low expected %h got %h", $time,
							exp_ct[63:0], cipher_low);
					end
				end
			end
		end
	end
endmodule

// ----- bench/tb_aes128_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// AES-128 block encryption testbench
// Directed vectors and ~1950 random blocks under several keys, with random
// gaps and output stalls; a side checker predicts and compares every block.
// ----------------------------------------------------------------------------
module tb_aes128_block_encrypt;
	import aes_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              valid_in = 1'b0;
	logic              stall_in;
	logic [HalfW-1:0]  plain_high = '0;
	logic [HalfW-1:0]  plain_low = '0;
	logic              valid_out;
	logic              stall_out = 1'b0;
	logic [HalfW-1:0]  cipher_high, cipher_low;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CfgIdxW:0]  cfg_index = '0;
	logic [HalfW-1:0]  cfg_data = '0;
	int                errors, pending, blocks_seen;
	bit                feeding_done = 1'b0;
	bit                hold_output = 1'b0;   // long receiver hold-off request
	int                key_phases = 0;

	always #10 clk = ~clk;

	aes128_block_encrypt uut (.*);

	aes128_cipher_checker chk (.*);

	// most gaps short, a few long, and stretches with none at all
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// receiver: random stalls, plus one long hold-off when asked
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				stall_out <= 1'b1;
				repeat (60) @(negedge clk);
				hold_output = 1'b0;
			end
			g = feeding_done ? 0 : pick_gap();
			if (g != 0) begin
				stall_out <= 1'b1;
				repeat (g) @(negedge clk);
			end
			stall_out <= 1'b0;
		end
	end

	// one block transfer: hold valid until accepted
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		int g;
		g = pick_gap();
		if (g != 0) begin
			valid_in <= 1'b0;
			repeat (g) @(negedge clk);
		end
		valid_in <= 1'b1;
		plain_high <= hi;
		plain_low <= lo;
		do @(posedge clk); while (stall_in);
		@(negedge clk);
	endtask

	// key writes only with the pipe drained
	task automatic write_key(input cfg_reg_t idx, input logic [63:0] val);
		valid_in <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (14) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= {1'b0, idx};
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_ignored_index();
		valid_in <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (14) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= {1'b1, 1'($urandom_range(0, 1))};
		cfg_data <= {$urandom, $urandom};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
		write_key(REG_KEY_HIGH, hi);
		write_key(REG_KEY_LOW, lo);
		key_phases++;
	endtask

	initial begin
		logic [63:0] kh, kl;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset key (zero), extremes and walking bits
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		set_key(64'h0001020304050607, 64'h08090A0B0C0D0E0F);
		send_block(64'h0011223344556677, 64'h8899AABBCCDDEEFF);
		set_key(64'h2B7E151628AED2A6, 64'hABF7158809CF4F3C);
		send_block(64'h3243F6A8885A308D, 64'h313198A2E0370734);
		set_key('1, '1);
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
		// an out-of-range register index leaves the key alone
		write_ignored_index();
		send_block(64'h8000000000000000, 64'h0000000000000001);
		for (int b = 0; b < 8; b++)
			send_block(64'h1 << (8 * b + b), 64'h1 << (63 - 8 * b));

		// random blocks under a series of random keys
		for (int ph = 0; ph < 6; ph++) begin
			kh = {$urandom, $urandom};
			kl = {$urandom, $urandom};
			if (ph == 5) begin kh = '0; kl = '1; end
			set_key(kh, kl);
			for (int i = 0; i < 325; i++) begin
				// ask for a long output hold-off while input keeps coming
				if (ph == 2 && i == 100) hold_output = 1'b1;
				send_block({$urandom, $urandom}, {$urandom, $urandom});
			end
		end
		valid_in <= 1'b0;
		feeding_done = 1'b1;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Checked %0d ciphertext blocks across %0d key settings,", blocks_seen,
			key_phases);
		$display("including zero/all-ones keys, an ignored register index and stalls.");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d blocks outstanding", pending);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
